// File: rtl/ymrx_pkg.sv
package ymrx_pkg;

  // block sizes of the two header kinds
  localparam logic [10:0] SHORT_BLOCK = 11'd128;
  localparam logic [10:0] LONG_BLOCK  = 11'd1024;

  // command queue depth, as an address width
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

  // bytes on the line
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_CAN = 8'h18;
  localparam logic [7:0] BYTE_C   = 8'h43;

  localparam logic [3:0] RETRY_FALLBACK = 4'd9;

  // configuration register indexes
  localparam logic CFG_POLL_WITH_NAK = 1'b0;
  localparam logic CFG_RETRY_LIMIT   = 1'b1;

  localparam logic [3:0] CFG_RETRY_RESET = 4'd10;

  typedef enum logic [1:0] {
    KIND_REPLY   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    V_DATA_OK   = 3'd0,
    V_HEADER_OK = 3'd1,
    V_DUPLICATE = 3'd2,
    V_BAD_CRC   = 3'd3,
    V_BAD_CMP   = 3'd4,
    V_DONE      = 3'd5,
    V_CANCELLED = 3'd6,
    V_FILE_END  = 3'd7
  } verdict_t;

  typedef enum logic [1:0] {
    TAIL_NONE   = 2'd0,
    TAIL_POLL   = 2'd1,
    TAIL_CANCEL = 2'd2
  } tail_t;

  // one input byte's worth of results, expanded by the back end
  typedef struct packed {
    logic        is_payload;
    logic [7:0]  pay_byte;
    logic [9:0]  pay_index;
    logic        has_reply;
    logic [7:0]  reply_byte;
    logic [15:0] bc_reply;
    logic        has_verdict;
    verdict_t    verdict;
    logic [15:0] bc_main;
    tail_t       tail;
    logic [7:0]  tail_byte;
    logic [3:0]  total;
  } cmd_t;

  // crc-16, poly 0x1021, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/ymodem_packet_receiver_core.sv
// ymodem receiver core, crc-16 mode, one line byte per transaction
// in channel: in_tdata carries the received byte, in_tuser = 1 starts a session
//   and sends the first poll (in_tdata ignored then)
// out channel: one transaction per result; out_tuser gives the kind (reply byte for
//   the sender, payload byte, verdict), out_tlast marks the last result of a byte
// cfg channel: cfg_index 0 is poll_with_nak, 1 is retry_limit; always ready,
//   write only while no results are pending
// a front stage decodes each byte combinationally and pushes a compact command
//   into a 4-entry queue; a back stage expands commands into results
// a byte's command enters the queue as its transaction is accepted; with out_tready
//   high, one byte per cycle is sustained while each causes at most one result,
//   otherwise the back stage emits one result per cycle (up to 12 for one byte)
//   and the queue absorbs the burst before in_tready drops
// reset: polling in 'C' mode, retry limit 10, waiting for a header, queue empty
// when out_tready is low the output register holds its result, the queue fills,
//   and in_tready falls once all four queue entries are taken
module ymodem_packet_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [17:8] payload_index,
                                  // [20:18] verdict, [36:21] block_count, [39:37] zero
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  // configuration registers
  logic       poll_with_nak_r;
  logic [3:0] retry_limit_r;

  logic            in_accept;
  logic            push;
  ymrx_pkg::cmd_t  push_cmd;
  ymrx_pkg::cmd_t  head;
  logic            head_valid;
  logic            pop;
  logic            fifo_full;

  logic [7:0]  res_byte;
  logic [9:0]  res_index;
  logic [2:0]  res_verdict;
  logic [15:0] res_bc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_with_nak_r <= 1'b0;
      retry_limit_r   <= ymrx_pkg::CFG_RETRY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ymrx_pkg::CFG_POLL_WITH_NAK: poll_with_nak_r <= cfg_data[0];
        ymrx_pkg::CFG_RETRY_LIMIT:   retry_limit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // the front stage stalls only on a full command queue
  assign in_tready = !fifo_full;
  assign in_accept = in_tvalid && in_tready;

  ymrx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .func          (in_tuser),
    .rx_byte       (in_tdata),
    .poll_with_nak (poll_with_nak_r),
    .retry_limit   (retry_limit_r),
    .push          (push),
    .cmd           (push_cmd)
  );

  ymrx_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (fifo_full)
  );

  ymrx_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_tuser),
    .out_byte    (res_byte),
    .out_index   (res_index),
    .out_verdict (res_verdict),
    .out_bc      (res_bc),
    .out_last    (out_tlast)
  );

  assign out_tdata = {3'b000, res_bc, res_verdict, res_index, res_byte};

endmodule

// File: rtl/ymrx_front.sv
module ymrx_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               func,
  input  logic [7:0]         rx_byte,
  input  logic               poll_with_nak,
  input  logic [3:0]         retry_limit,
  output logic               push,
  output ymrx_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_BLK  = 4'b0010,
    PH_CMP  = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        long_r, long_nxt;
  logic [7:0]  blk_r, blk_nxt;
  logic [10:0] left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic        zero_r, zero_nxt;
  logic [7:0]  last_blk_r, last_blk_nxt;
  logic [7:0]  wrap_r, wrap_nxt;
  logic        hdr_seen_r, hdr_seen_nxt;
  logic        file_act_r, file_act_nxt;
  logic        nak_style_r, nak_style_nxt;
  logic [3:0]  retries_r, retries_nxt;
  logic        finished_r, finished_nxt;

  logic        poll_req;
  logic        poll_ns;
  logic [3:0]  poll_r;
  logic [10:0] blk_len;
  logic [10:0] pay_pos;
  logic [7:0]  blk_diff;
  logic        crc_ok;
  logic [3:0]  tail_cnt;

  assign blk_len  = long_r ? ymrx_pkg::LONG_BLOCK : ymrx_pkg::SHORT_BLOCK;
  assign pay_pos  = blk_len + 11'd2 - left_r;
  assign blk_diff = blk_r - last_blk_r;
  assign crc_ok   = (crc_r[15:8] == crc_hi_r) && (crc_r[7:0] == rx_byte);

  always_comb begin
    phase_nxt     = phase_r;
    long_nxt      = long_r;
    blk_nxt       = blk_r;
    left_nxt      = left_r;
    crc_nxt       = crc_r;
    crc_hi_nxt    = crc_hi_r;
    zero_nxt      = zero_r;
    last_blk_nxt  = last_blk_r;
    wrap_nxt      = wrap_r;
    hdr_seen_nxt  = hdr_seen_r;
    file_act_nxt  = file_act_r;
    nak_style_nxt = nak_style_r;
    retries_nxt   = retries_r;
    finished_nxt  = finished_r;
    poll_req      = 1'b0;
    poll_ns       = nak_style_r;
    poll_r        = retries_r;

    cmd             = '0;
    cmd.verdict     = ymrx_pkg::V_DATA_OK;
    cmd.tail        = ymrx_pkg::TAIL_NONE;
    cmd.bc_reply    = {wrap_r, last_blk_r};

    if (func) begin
      last_blk_nxt  = 8'd0;
      wrap_nxt      = 8'd0;
      hdr_seen_nxt  = 1'b0;
      left_nxt      = 11'd0;
      file_act_nxt  = 1'b0;
      finished_nxt  = 1'b0;
      nak_style_nxt = poll_with_nak;
      poll_req      = 1'b1;
      poll_ns       = poll_with_nak;
      poll_r        = retry_limit;
    end else if (!finished_r) begin
      case (phase_r)
        PH_HEAD: begin
          if (rx_byte == ymrx_pkg::BYTE_SOH || rx_byte == ymrx_pkg::BYTE_STX) begin
            long_nxt  = (rx_byte == ymrx_pkg::BYTE_STX);
            crc_nxt   = 16'd0;
            zero_nxt  = 1'b1;
            phase_nxt = PH_BLK;
          end else if (rx_byte == ymrx_pkg::BYTE_EOT) begin
            if (file_act_r) begin
              file_act_nxt    = 1'b0;
              cmd.has_reply   = 1'b1;
              cmd.reply_byte  = ymrx_pkg::BYTE_NAK;
              cmd.has_verdict = 1'b1;
              cmd.verdict     = ymrx_pkg::V_FILE_END;
            end else begin
              // no file open: session numbering restarts
              last_blk_nxt   = 8'd0;
              wrap_nxt       = 8'd0;
              left_nxt       = 11'd0;
              hdr_seen_nxt   = 1'b0;
              cmd.has_reply  = 1'b1;
              cmd.reply_byte = ymrx_pkg::BYTE_ACK;
              cmd.bc_reply   = 16'd0;
              poll_req       = 1'b1;
            end
          end
        end
        PH_BLK: begin
          blk_nxt   = rx_byte;
          phase_nxt = PH_CMP;
        end
        PH_CMP: begin
          if ((rx_byte ^ blk_r) == 8'hFF) begin
            left_nxt  = blk_len + 11'd2;
            phase_nxt = PH_DATA;
          end else begin
            cmd.has_verdict = 1'b1;
            cmd.verdict     = ymrx_pkg::V_BAD_CMP;
            poll_req        = 1'b1;
          end
        end
        PH_DATA: begin
          if (left_r > 11'd2) begin
            cmd.is_payload = 1'b1;
            cmd.pay_byte   = rx_byte;
            cmd.pay_index  = pay_pos[9:0];
            crc_nxt        = ymrx_pkg::crc16_byte(crc_r, rx_byte);
            if (rx_byte != 8'd0) zero_nxt = 1'b0;
            left_nxt       = left_r - 11'd1;
          end else if (left_r == 11'd2) begin
            crc_hi_nxt = rx_byte;
            left_nxt   = 11'd1;
          end else if (left_r == 11'd1) begin
            left_nxt  = 11'd0;
            phase_nxt = PH_HEAD;
            if (!crc_ok) begin
              cmd.has_verdict = 1'b1;
              cmd.verdict     = ymrx_pkg::V_BAD_CRC;
              poll_req        = 1'b1;
            end else if (blk_r == 8'd0 && !hdr_seen_r && zero_r) begin
              // empty block zero before any header ends the session
              cmd.has_reply   = 1'b1;
              cmd.reply_byte  = ymrx_pkg::BYTE_ACK;
              cmd.has_verdict = 1'b1;
              cmd.verdict     = ymrx_pkg::V_DONE;
              finished_nxt    = 1'b1;
            end else if (blk_diff > 8'd1) begin
              cmd.tail     = ymrx_pkg::TAIL_CANCEL;
              finished_nxt = 1'b1;
            end else begin
              cmd.has_reply   = 1'b1;
              cmd.reply_byte  = ymrx_pkg::BYTE_ACK;
              cmd.has_verdict = 1'b1;
              nak_style_nxt   = 1'b0;
              retries_nxt     = retry_limit;
              if (hdr_seen_r && blk_r == last_blk_r) begin
                cmd.verdict = ymrx_pkg::V_DUPLICATE;
              end else begin
                last_blk_nxt = blk_r;
                if (blk_diff == 8'd0 && !hdr_seen_r) begin
                  hdr_seen_nxt = 1'b1;
                  file_act_nxt = 1'b1;
                  cmd.verdict  = ymrx_pkg::V_HEADER_OK;
                  poll_req     = 1'b1;
                  poll_ns      = 1'b0;
                  poll_r       = retry_limit;
                end else begin
                  if (blk_r == 8'd0) wrap_nxt = wrap_r + 8'd1;
                  cmd.verdict = ymrx_pkg::V_DATA_OK;
                end
              end
            end
          end else begin
            phase_nxt = PH_HEAD;
          end
        end
        default: begin
          phase_nxt = PH_HEAD;
        end
      endcase
    end

    // poll the sender, falling back or cancelling when retries are gone
    if (poll_req) begin
      phase_nxt = PH_HEAD;
      if (poll_r == 4'd0) begin
        if (!poll_ns) begin
          retries_nxt   = ymrx_pkg::RETRY_FALLBACK;
          cmd.tail      = ymrx_pkg::TAIL_POLL;
          cmd.tail_byte = ymrx_pkg::BYTE_C;
        end else begin
          cmd.tail     = ymrx_pkg::TAIL_CANCEL;
          finished_nxt = 1'b1;
        end
      end else begin
        retries_nxt   = poll_r - 4'd1;
        cmd.tail      = ymrx_pkg::TAIL_POLL;
        cmd.tail_byte = poll_ns ? ymrx_pkg::BYTE_NAK : ymrx_pkg::BYTE_C;
      end
    end

    cmd.bc_main = {wrap_nxt, last_blk_nxt};

    case (cmd.tail)
      ymrx_pkg::TAIL_POLL:   tail_cnt = 4'd1;
      ymrx_pkg::TAIL_CANCEL: tail_cnt = 4'd11;
      default:               tail_cnt = 4'd0;
    endcase
    cmd.total = cmd.is_payload ? 4'd1
              : ({3'd0, cmd.has_reply} + {3'd0, cmd.has_verdict} + tail_cnt);
  end

  assign push = accept && (cmd.total != 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD;
      long_r      <= 1'b0;
      blk_r       <= 8'd0;
      left_r      <= 11'd0;
      crc_r       <= 16'd0;
      crc_hi_r    <= 8'd0;
      zero_r      <= 1'b1;
      last_blk_r  <= 8'd0;
      wrap_r      <= 8'd0;
      hdr_seen_r  <= 1'b0;
      file_act_r  <= 1'b0;
      nak_style_r <= 1'b0;
      retries_r   <= ymrx_pkg::CFG_RETRY_RESET;
      finished_r  <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      long_r      <= long_nxt;
      blk_r       <= blk_nxt;
      left_r      <= left_nxt;
      crc_r       <= crc_nxt;
      crc_hi_r    <= crc_hi_nxt;
      zero_r      <= zero_nxt;
      last_blk_r  <= last_blk_nxt;
      wrap_r      <= wrap_nxt;
      hdr_seen_r  <= hdr_seen_nxt;
      file_act_r  <= file_act_nxt;
      nak_style_r <= nak_style_nxt;
      retries_r   <= retries_nxt;
      finished_r  <= finished_nxt;
    end
  end

endmodule

// File: rtl/ymrx_cmd_fifo.sv
module ymrx_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ymrx_pkg::cmd_t push_cmd,
  input  logic           pop,
  output ymrx_pkg::cmd_t head,
  output logic           not_empty,
  output logic           full
);

  ymrx_pkg::cmd_t                 mem_r [ymrx_pkg::FIFO_DEPTH];
  logic [ymrx_pkg::FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [ymrx_pkg::FIFO_AW:0]     count_r, count_nxt;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == ymrx_pkg::FIFO_AW'(0) + (ymrx_pkg::FIFO_AW+1)'(ymrx_pkg::FIFO_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/ymrx_back.sv
module ymrx_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ymrx_pkg::cmd_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_byte,
  output logic [9:0]     out_index,
  output logic [2:0]     out_verdict,
  output logic [15:0]    out_bc,
  output logic           out_last
);

  logic        valid_r;
  logic [3:0]  step_r;
  logic        advance;
  logic        item_last;
  logic [3:0]  tail_step;
  logic [3:0]  verdict_step;

  ymrx_pkg::kind_t    kind_nxt;
  logic [7:0]         byte_nxt;
  logic [9:0]         index_nxt;
  ymrx_pkg::verdict_t verdict_nxt;
  logic [15:0]        bc_nxt;

  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [9:0]  index_r;
  logic [2:0]  verdict_r;
  logic [15:0] bc_r;
  logic        last_r;

  assign advance      = head_valid && (!valid_r || out_ready);
  assign item_last    = (step_r == head.total - 4'd1);
  assign pop          = advance && item_last;
  assign verdict_step = {3'd0, head.has_reply};
  assign tail_step    = step_r - {3'd0, head.has_reply} - {3'd0, head.has_verdict};

  // pick the item at the current step of the head command
  always_comb begin
    kind_nxt    = ymrx_pkg::KIND_REPLY;
    byte_nxt    = 8'd0;
    index_nxt   = 10'd0;
    verdict_nxt = ymrx_pkg::V_DATA_OK;
    bc_nxt      = head.bc_main;
    if (head.is_payload) begin
      kind_nxt  = ymrx_pkg::KIND_PAYLOAD;
      byte_nxt  = head.pay_byte;
      index_nxt = head.pay_index;
    end else if (head.has_reply && step_r == 4'd0) begin
      byte_nxt = head.reply_byte;
      bc_nxt   = head.bc_reply;
    end else if (head.has_verdict && step_r == verdict_step) begin
      kind_nxt    = ymrx_pkg::KIND_VERDICT;
      verdict_nxt = head.verdict;
    end else if (head.tail == ymrx_pkg::TAIL_POLL) begin
      byte_nxt = head.tail_byte;
    end else if (tail_step < 4'd5) begin
      byte_nxt = ymrx_pkg::BYTE_CAN;
    end else if (tail_step < 4'd10) begin
      byte_nxt = ymrx_pkg::BYTE_BS;
    end else begin
      kind_nxt    = ymrx_pkg::KIND_VERDICT;
      verdict_nxt = ymrx_pkg::V_CANCELLED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 4'd0;
    end else begin
      if (advance) begin
        valid_r <= 1'b1;
        step_r  <= item_last ? 4'd0 : step_r + 4'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r    <= kind_nxt;
      byte_r    <= byte_nxt;
      index_r   <= index_nxt;
      verdict_r <= verdict_nxt;
      bc_r      <= bc_nxt;
      last_r    <= item_last;
    end
  end

  assign out_valid   = valid_r;
  assign out_kind    = kind_r;
  assign out_byte    = byte_r;
  assign out_index   = index_r;
  assign out_verdict = verdict_r;
  assign out_bc      = bc_r;
  assign out_last    = last_r;

endmodule

// File: dv/ymodem_packet_receiver_core_tb.sv
module ymodem_packet_receiver_core_tb;
  import ymrx_pkg::*;

  // what one result transaction carries, unpacked
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [9:0]  idx;
    verdict_t    verdict;
    logic [15:0] blocks;
    logic        is_last;
  } rx_result_t;

  // where the receiver stands within a packet
  typedef enum logic [1:0] {RD_HEAD, RD_BLK, RD_CMP, RD_DATA} rd_phase_t;

  // directed rows: what to send and, for some, the final result typed in by hand
  typedef enum logic [1:0] {ACT_START, ACT_BYTE, ACT_PACKET, ACT_CFG} act_t;
  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_COUNT} fill_t;
  typedef enum logic [1:0] {FLAW_NONE, FLAW_CMP, FLAW_CRC} flaw_t;

  typedef struct packed {
    act_t       act;
    logic       reg_idx;
    logic [7:0] val;       // line byte, block number or register value
    logic       long_blk;
    fill_t      fill;
    flaw_t      flaw;
    logic       typed;
    kind_t      t_kind;
    logic [7:0] t_byte;
    verdict_t   t_verdict;
  } plan_row_t;

  localparam int N_PLAN      = 26;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  localparam plan_row_t PLAN [N_PLAN] = '{
    // stray bytes before any session
    '{ACT_BYTE, 1'b0, 8'h00, 1'b0, FILL_ZERO, FLAW_NONE, 1'b0, KIND_REPLY, 8'h00, V_DATA_OK},
    '{ACT_BYTE, 1'b0, 8'hFF, 1'b0, FILL_ZERO, FLAW_NONE, 1'b0, KIND_REPLY, 8'h00, V_DATA_OK},
    '{ACT_START, 1'b0, 8'h00, 1'b0, FILL_ZERO, FLAW_NONE, 1'b1, KIND_REPLY, BYTE_C, V_DATA_OK},
    // empty block zero ends the batch, then bytes are dropped
    '{ACT_PACKET, 1'b0, 8'd0, 1'b0, FILL_ZERO, FLAW_NONE, 1'b1, KIND_VERDICT, 8'h00, V_DONE},
    '{ACT_BYTE, 1'b0, BYTE_SOH, 1'b0, FILL_ZERO, FLAW_NONE, 1'b0, KIND_REPLY, 8'h00, V_DATA_OK},
    '{ACT_START, 1'b0, 8'h00, 1'b0, FILL_ZERO, FLAW_NONE, 1'b1, KIND_REPLY, BYTE_C, V_DATA_OK},
    // file header block, then a long data block with every index
    '{ACT_PACKET, 1'b0, 8'd0, 1'b0, FILL_RANDOM, FLAW_NONE, 1'b1, KIND_REPLY, BYTE_C, V_DATA_OK},
    '{ACT_PACKET, 1'b0, 8'd1, 1'b1, FILL_COUNT, FLAW_NONE, 1'b1, KIND_VERDICT, 8'h00, V_DATA_OK},
    '{ACT_PACKET, 1'b0, 8'd1, 1'b0, FILL_ONES, FLAW_NONE, 1'b1, KIND_VERDICT, 8'h00, V_DUPLICATE},
    '{ACT_PACKET, 1'b0, 8'd2, 1'b0, FILL_RANDOM, FLAW_CRC, 1'b1, KIND_REPLY, BYTE_C, V_DATA_OK},
    '{ACT_PACKET, 1'b0, 8'd2, 1'b1, FILL_RANDOM, FLAW_CMP, 1'b1, KIND_REPLY, BYTE_C, V_DATA_OK},
    '{ACT_BYTE, 1'b0, 8'h03, 1'b0, FILL_ZERO, FLAW_NONE, 1'b0, KIND_REPLY, 8'h00, V_DATA_OK},
    // eot closes the file, a second eot restarts numbering
    '{ACT_BYTE, 1'b0, BYTE_EOT, 1'b0, FILL_ZERO, FLAW_NONE, 1'b1, KIND_VERDICT, 8'h00, V_FILE_END},
    '{ACT_BYTE, 1'b0, BYTE_EOT, 1'b0, FILL_ZERO, FLAW_NONE, 1'b1, KIND_REPLY, BYTE_C, V_DATA_OK},
    '{ACT_PACKET, 1'b0, 8'd0, 1'b0, FILL_RANDOM, FLAW_NONE, 1'b1, KIND_REPLY, BYTE_C, V_DATA_OK},
    // block number jumps too far
    '{ACT_PACKET, 1'b0, 8'hFF, 1'b0, FILL_RANDOM, FLAW_NONE, 1'b1, KIND_VERDICT, 8'h00,
      V_CANCELLED},
    // nak polling with a single retry
    '{ACT_CFG, CFG_POLL_WITH_NAK, 8'd1, 1'b0, FILL_ZERO, FLAW_NONE, 1'b0, KIND_REPLY, 8'h00,
      V_DATA_OK},
    '{ACT_CFG, CFG_RETRY_LIMIT, 8'd1, 1'b0, FILL_ZERO, FLAW_NONE, 1'b0, KIND_REPLY, 8'h00,
      V_DATA_OK},
    '{ACT_START, 1'b0, 8'h00, 1'b0, FILL_ZERO, FLAW_NONE, 1'b1, KIND_REPLY, BYTE_NAK, V_DATA_OK},
    '{ACT_PACKET, 1'b0, 8'd0, 1'b0, FILL_RANDOM, FLAW_CMP, 1'b1, KIND_VERDICT, 8'h00,
      V_CANCELLED},
    '{ACT_START, 1'b0, 8'h00, 1'b0, FILL_ZERO, FLAW_NONE, 1'b1, KIND_REPLY, BYTE_NAK, V_DATA_OK},
    '{ACT_PACKET, 1'b0, 8'd0, 1'b0, FILL_RANDOM, FLAW_CRC, 1'b1, KIND_VERDICT, 8'h00,
      V_CANCELLED},
    '{ACT_START, 1'b0, 8'h00, 1'b0, FILL_ZERO, FLAW_NONE, 1'b1, KIND_REPLY, BYTE_NAK, V_DATA_OK},
    // accepted header switches to 'C', then the retry count falls back
    '{ACT_PACKET, 1'b0, 8'd0, 1'b0, FILL_RANDOM, FLAW_NONE, 1'b1, KIND_REPLY, BYTE_C, V_DATA_OK},
    '{ACT_PACKET, 1'b0, 8'd1, 1'b0, FILL_RANDOM, FLAW_CMP, 1'b1, KIND_REPLY, BYTE_C, V_DATA_OK},
    '{ACT_PACKET, 1'b0, 8'd1, 1'b0, FILL_ZERO, FLAW_NONE, 1'b1, KIND_VERDICT, 8'h00, V_DATA_OK}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] rx_byte
  logic        in_tuser   = 1'b0;    // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;            // [7:0] out_byte, [17:8] payload_index,
                                     // [20:18] verdict, [36:21] block_count, [39:37] zero
  logic [1:0]  out_tuser;            // [1:0] out_kind
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = 1'b0;
  logic [3:0]  cfg_data   = 4'd0;

  ymodem_packet_receiver_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // run control
  logic failed   = 1'b0;
  logic quiet    = 1'b0;   // no idling on either side
  logic hold_req = 1'b0;   // ask the result side for one long hold-off
  int   items_sent = 0;
  int   step_count = 0;    // results caused by the latest accepted byte

  rx_result_t reply_q [$];   // results still owed by the block, oldest first
  rx_result_t step_res [$];  // results of the byte being predicted

  // receiver mirror: registers and session state
  logic        cfg_nak   = 1'b0;
  logic [3:0]  cfg_retry = CFG_RETRY_RESET;
  rd_phase_t   rd_phase  = RD_HEAD;
  logic        is_long   = 1'b0;
  logic [7:0]  blk_num   = 8'h00;
  logic [10:0] left_cnt  = 11'd0;
  logic [15:0] crc_run   = 16'h0000;
  logic [7:0]  crc_hi    = 8'h00;
  logic        all_zero  = 1'b1;
  logic [7:0]  prev_blk  = 8'h00;
  logic [7:0]  wraps     = 8'h00;
  logic        hdr_seen  = 1'b0;
  logic        file_open = 1'b0;
  logic        nak_mode  = 1'b0;
  logic [3:0]  tries     = CFG_RETRY_RESET;
  logic        done      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // crc-16 ccitt, msb first, one byte
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void put_result(kind_t k, logic [7:0] b, logic [9:0] ix, verdict_t v);
    rx_result_t r;
    if (step_res.size() >= 12) return;
    r.kind    = k;
    r.data    = b;
    r.idx     = ix;
    r.verdict = v;
    r.blocks  = {wraps, prev_blk};
    r.is_last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void abort_session();
    repeat (5) put_result(KIND_REPLY, BYTE_CAN, 10'd0, V_DATA_OK);
    repeat (5) put_result(KIND_REPLY, BYTE_BS, 10'd0, V_DATA_OK);
    put_result(KIND_VERDICT, 8'h00, 10'd0, V_CANCELLED);
    done     = 1'b1;
    rd_phase = RD_HEAD;
  endfunction

  // poll, spending a retry; out of retries: 'C' mode falls back, nak mode gives up
  function automatic void poll_sender();
    if (tries == 4'd0) begin
      if (!nak_mode) begin
        tries = RETRY_FALLBACK;
      end else begin
        abort_session();
        return;
      end
    end else begin
      tries = tries - 4'd1;
    end
    put_result(KIND_REPLY, nak_mode ? BYTE_NAK : BYTE_C, 10'd0, V_DATA_OK);
    rd_phase = RD_HEAD;
  endfunction

  function automatic void judge_packet(input logic [7:0] crc_lo);
    logic [7:0] ahead;
    if (crc_run != {crc_hi, crc_lo}) begin
      put_result(KIND_VERDICT, 8'h00, 10'd0, V_BAD_CRC);
      poll_sender();
      return;
    end
    if (blk_num == 8'h00 && !hdr_seen && all_zero) begin
      put_result(KIND_REPLY, BYTE_ACK, 10'd0, V_DATA_OK);
      put_result(KIND_VERDICT, 8'h00, 10'd0, V_DONE);
      done = 1'b1;
      return;
    end
    ahead = blk_num - prev_blk;
    if (ahead > 8'd1) begin
      abort_session();
      return;
    end
    put_result(KIND_REPLY, BYTE_ACK, 10'd0, V_DATA_OK);
    nak_mode = 1'b0;
    tries    = cfg_retry;
    if (hdr_seen && blk_num == prev_blk) begin
      put_result(KIND_VERDICT, 8'h00, 10'd0, V_DUPLICATE);
      return;
    end
    prev_blk = blk_num;
    if (ahead == 8'd0 && !hdr_seen) begin
      hdr_seen  = 1'b1;
      file_open = 1'b1;
      put_result(KIND_VERDICT, 8'h00, 10'd0, V_HEADER_OK);
      poll_sender();
      return;
    end
    if (prev_blk == 8'h00) wraps = wraps + 8'd1;
    put_result(KIND_VERDICT, 8'h00, 10'd0, V_DATA_OK);
  endfunction

  // advance the mirror by one accepted byte and queue what it owes
  function automatic void predict_byte(input logic f, input logic [7:0] b);
    logic [10:0] len;
    step_res.delete();
    len = is_long ? LONG_BLOCK : SHORT_BLOCK;
    if (f) begin
      prev_blk  = 8'h00;
      wraps     = 8'h00;
      hdr_seen  = 1'b0;
      left_cnt  = 11'd0;
      file_open = 1'b0;
      done      = 1'b0;
      nak_mode  = cfg_nak;
      tries     = cfg_retry;
      poll_sender();
    end else if (!done) begin
      case (rd_phase)
        RD_HEAD: begin
          if (b == BYTE_SOH || b == BYTE_STX) begin
            is_long  = (b == BYTE_STX);
            crc_run  = 16'h0000;
            all_zero = 1'b1;
            rd_phase = RD_BLK;
          end else if (b == BYTE_EOT) begin
            if (file_open) begin
              file_open = 1'b0;
              put_result(KIND_REPLY, BYTE_NAK, 10'd0, V_DATA_OK);
              put_result(KIND_VERDICT, 8'h00, 10'd0, V_FILE_END);
            end else begin
              prev_blk = 8'h00;
              wraps    = 8'h00;
              left_cnt = 11'd0;
              hdr_seen = 1'b0;
              put_result(KIND_REPLY, BYTE_ACK, 10'd0, V_DATA_OK);
              poll_sender();
            end
          end
        end
        RD_BLK: begin
          blk_num  = b;
          rd_phase = RD_CMP;
        end
        RD_CMP: begin
          if ((b ^ blk_num) == 8'hFF) begin
            left_cnt = len + 11'd2;
            rd_phase = RD_DATA;
          end else begin
            put_result(KIND_VERDICT, 8'h00, 10'd0, V_BAD_CMP);
            poll_sender();
          end
        end
        RD_DATA: begin
          if (left_cnt > 11'd2) begin
            put_result(KIND_PAYLOAD, b, 10'(len + 11'd2 - left_cnt), V_DATA_OK);
            crc_run = crc16_next(crc_run, b);
            if (b != 8'h00) all_zero = 1'b0;
            left_cnt = left_cnt - 11'd1;
          end else if (left_cnt == 11'd2) begin
            crc_hi   = b;
            left_cnt = 11'd1;
          end else if (left_cnt == 11'd1) begin
            left_cnt = 11'd0;
            rd_phase = RD_HEAD;
            judge_packet(b);
          end else begin
            rd_phase = RD_HEAD;
          end
        end
        default: rd_phase = RD_HEAD;
      endcase
    end
    step_count = step_res.size();
    if (step_count > 0) step_res[step_count - 1].is_last = 1'b1;
    foreach (step_res[i]) reply_q.push_back(step_res[i]);
  endfunction

  // one line byte (or start) per input transaction, random gap before some unless quiet
  task automatic push_item(input logic f, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_byte(f, b);
    items_sent++;
  endtask

  // header, block number, complement, payload and crc; a flawed complement stops early
  task automatic send_packet(input logic long_blk, input logic [7:0] blk, input fill_t fill,
                             input flaw_t flaw);
    logic [15:0] crc;
    logic [7:0]  d;
    int          len;
    len = long_blk ? LONG_BLOCK : SHORT_BLOCK;
    push_item(1'b0, long_blk ? BYTE_STX : BYTE_SOH);
    push_item(1'b0, blk);
    if (flaw == FLAW_CMP) begin
      push_item(1'b0, ~blk ^ (8'h01 << $urandom_range(0, 7)));
      return;
    end
    push_item(1'b0, ~blk);
    crc = 16'h0000;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: d = 8'h00;
        FILL_ONES: d = 8'hFF;
        FILL_COUNT: d = 8'(i);
        default: d = 8'($urandom_range(0, 255));
      endcase
      crc = crc16_next(crc, d);
      push_item(1'b0, d);
    end
    if (flaw == FLAW_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    push_item(1'b0, crc[15:8]);
    push_item(1'b0, crc[7:0]);
  endtask

  // stop sending and wait until every owed result has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_POLL_WITH_NAK) cfg_nak = val[0];
    else cfg_retry = val;
    @(posedge clk);
  endtask

  // 55% packets, mostly well-formed with random content; the rest restarts, eot and junk
  task automatic random_phase(input int budget);
    int         stop_at;
    int         pick;
    logic [7:0] blk;
    logic       long_blk;
    flaw_t      flaw;
    fill_t      fill;
    stop_at = items_sent + budget;
    push_item(1'b1, 8'($urandom_range(0, 255)));
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (done && $urandom_range(0, 1) == 0) begin
        push_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
        case ($urandom_range(0, 9))
          0: blk = prev_blk;
          1: blk = prev_blk + 8'($urandom_range(2, 255));
          default: blk = prev_blk + 8'd1;
        endcase
        if (!hdr_seen && $urandom_range(0, 2) != 0) blk = 8'h00;
        case ($urandom_range(0, 9))
          0: flaw = FLAW_CRC;
          1: flaw = FLAW_CMP;
          default: flaw = FLAW_NONE;
        endcase
        case ($urandom_range(0, 9))
          0: fill = FILL_ZERO;
          1: fill = FILL_ONES;
          default: fill = FILL_RANDOM;
        endcase
        // long payloads are costly: only where the complement cuts them short
        long_blk = (flaw == FLAW_CMP) ? 1'($urandom_range(0, 1)) : 1'b0;
        send_packet(long_blk, blk, fill, flaw);
      end else if (pick < 65) begin
        push_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 75) begin
        push_item(1'b0, BYTE_EOT);
      end else if (pick < 85) begin
        // header cut off after a few bytes
        push_item(1'b0, $urandom_range(0, 1) ? BYTE_STX : BYTE_SOH);
        repeat ($urandom_range(0, 3)) push_item(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) push_item(1'b0, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // result side: random stalls, one long hold-off on request, none when quiet
  initial begin : result_sink
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // every result transaction against the oldest owed result
  always @(posedge clk) begin : result_check
    rx_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result: kind %0d byte %0h verdict %0d", out_tuser,
               out_tdata[7:0], out_tdata[20:18]);
        failed = 1'b1;
      end else begin
        want = reply_q.pop_front();
        check_field("out_kind", want.kind, out_tuser);
        check_field("out_byte", want.data, out_tdata[7:0]);
        check_field("payload_index", want.idx, out_tdata[17:8]);
        check_field("verdict", want.verdict, out_tdata[20:18]);
        check_field("block_count", want.blocks, out_tdata[36:21]);
        check_field("last", want.is_last, out_tlast);
      end
    end
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #800000;
    $display("** ymodem_packet_receiver_core: FAILED **");
    $finish;
  end

  initial begin
    plan_row_t  row;
    rx_result_t pinned;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; typed rows fix the final result of that row by hand
    for (int r = 0; r < N_PLAN; r++) begin
      row = PLAN[r];
      case (row.act)
        ACT_START: push_item(1'b1, 8'($urandom_range(0, 255)));
        ACT_BYTE: push_item(1'b0, row.val);
        ACT_PACKET: send_packet(row.long_blk, row.val, row.fill, row.flaw);
        default: write_reg(row.reg_idx, row.val[3:0]);
      endcase
      if (row.typed) begin
        if (step_count == 0) begin
          $error("row %0d: no result where one is listed", r);
          failed = 1'b1;
        end else begin
          pinned         = reply_q[reply_q.size() - 1];
          pinned.kind    = row.t_kind;
          pinned.data    = row.t_byte;
          pinned.verdict = row.t_verdict;
          reply_q[reply_q.size() - 1] = pinned;
        end
      end
    end

    // 'C' polling, widest retry count, with the long result-side hold-off
    write_reg(CFG_POLL_WITH_NAK, 4'd0);
    write_reg(CFG_RETRY_LIMIT, 4'd15);
    hold_req = 1'b1;
    random_phase(200);

    write_reg(CFG_POLL_WITH_NAK, 4'd1);
    write_reg(CFG_RETRY_LIMIT, 4'($urandom_range(1, 15)));
    random_phase(200);

    // last stretch at full rate on both sides
    write_reg(CFG_POLL_WITH_NAK, 4'd0);
    write_reg(CFG_RETRY_LIMIT, 4'd1);
    quiet = 1'b1;
    random_phase(120);

    drain_results();
    if (!failed) begin
      $display("** ymodem_packet_receiver_core: PASSED **");
    end else begin
      $display("** ymodem_packet_receiver_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ymrx_pkg.sv
rtl/ymrx_front.sv
rtl/ymrx_cmd_fifo.sv
rtl/ymrx_back.sv
rtl/ymodem_packet_receiver_core.sv
dv/ymodem_packet_receiver_core_tb.sv
